/* hdl/tlb_fifo_lru_replacement_core_assert.svh */
// Assertion macros for the translation buffer core.
`ifndef TLB_FIFO_LRU_REPLACEMENT_CORE_ASSERT_SVH
`define TLB_FIFO_LRU_REPLACEMENT_CORE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define TFL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define TFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/tfl_pkg.sv */
// Shared types and constants of the translation buffer core.
package tfl_pkg;

	localparam int TFL_MAX_ENTRIES = 16;
	localparam int TFL_PID_BITS    = 16;
	localparam int TFL_PAGE_BITS   = 20;
	localparam int TFL_FRAME_BITS  = 20;
	localparam int TFL_STAMP_BITS  = 32;
	localparam int TFL_EIU_BITS    = 5;

	localparam logic REG_ENTRIES = 1'b0;
	localparam logic REG_POLICY  = 1'b1;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_FLUSH  = 2'd2,
		OP_NONE   = 2'd3
	} tfl_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} tfl_state_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic touch;
	} tfl_cell_cmd_t;

endpackage

/* hdl/tfl_cell.sv */
// One entry of the translation list: storage, key compare and neighbor shift.
module tfl_cell
	import tfl_pkg::*;
#(
	parameter int PID_BITS   = TFL_PID_BITS,
	parameter int PAGE_BITS  = TFL_PAGE_BITS,
	parameter int FRAME_BITS = TFL_FRAME_BITS
) (
	input  logic                      clk,
	input  tfl_cell_cmd_t             cmd,
	input  logic                      valid,
	input  logic [PID_BITS-1:0]       key_pid,
	input  logic [PAGE_BITS-1:0]      key_page,
	input  logic [FRAME_BITS-1:0]     new_frame,
	input  logic [TFL_STAMP_BITS-1:0] stamp_now,
	input  logic [PID_BITS-1:0]       nb_pid,
	input  logic [PAGE_BITS-1:0]      nb_page,
	input  logic [FRAME_BITS-1:0]     nb_frame,
	input  logic [TFL_STAMP_BITS-1:0] nb_stamp,
	input  logic                      found_in,
	output logic                      found_out,
	output logic                      first,
	output logic [PID_BITS-1:0]       pid,
	output logic [PAGE_BITS-1:0]      page,
	output logic [FRAME_BITS-1:0]     frame,
	output logic [TFL_STAMP_BITS-1:0] stamp
);

	logic [PID_BITS-1:0]       pid_q;
	logic [PAGE_BITS-1:0]      page_q;
	logic [FRAME_BITS-1:0]     frame_q;
	logic [TFL_STAMP_BITS-1:0] stamp_q;
	logic                      match;

	always_ff @(posedge clk) begin
		priority if (cmd.load) begin
			pid_q   <= key_pid;
			page_q  <= key_page;
			frame_q <= new_frame;
			stamp_q <= stamp_now;
		end else if (cmd.shift) begin
			pid_q   <= nb_pid;
			page_q  <= nb_page;
			frame_q <= nb_frame;
			stamp_q <= nb_stamp;
		end else if (cmd.touch) begin
			stamp_q <= stamp_now;
		end else begin
			// hold
		end
	end

	assign match     = valid && (pid_q == key_pid) && (page_q == key_page);
	assign first     = match && !found_in;
	assign found_out = found_in || match;
	assign pid       = pid_q;
	assign page      = page_q;
	assign frame     = frame_q;
	assign stamp     = stamp_q;

endmodule

/* hdl/tfl_victim_scan.sv */
// Least-recently-used victim search, one stamp per cycle.
module tfl_victim_scan
	import tfl_pkg::*;
#(
	parameter int MAX_ENTRIES = TFL_MAX_ENTRIES,
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic                                        run,
	input  logic [MAX_ENTRIES-1:0][TFL_STAMP_BITS-1:0] stamps,
	input  logic [CW-1:0]                               count,
	output logic [IW-1:0]                               victim,
	output logic                                        last
);

	logic [IW-1:0]             idx_q;
	logic [IW-1:0]             victim_q;
	logic [TFL_STAMP_BITS-1:0] best_q;
	logic                      lower;

	assign lower = stamps[idx_q] < best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			victim_q <= '0;
		end else if (start) begin
			idx_q    <= IW'(1);
			victim_q <= '0;
		end else if (run) begin
			idx_q <= idx_q + IW'(1);
			if (lower) begin
				victim_q <= idx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			best_q <= stamps[0];
		end else if (run && lower) begin
			best_q <= stamps[idx_q];
		end
	end

	assign victim = victim_q;
	assign last   = run && (CW'(idx_q) == count - CW'(1));

endmodule

/* hdl/tlb_fifo_lru_replacement_core.sv */
// Top level of the fully associative translation buffer with FIFO/LRU replacement.
//
//  channel  | role   | payload
//  ---------+--------+------------------------------------------------------
//  s_axis   | in     | tuser: opcode; tdata: process_id, page_number, frame_number
//  m_axis   | out    | tuser: hit, replaced; tdata: frame_out
//  apb      | config | entries_in_use at 0x0, policy_lru at 0x4
//
// Lookups, flushes, FIFO inserts and inserts into a list that is not full execute as soon as taken.
// An LRU insert into a full list of n > 1 entries searches first: the victim unit reads one
// stamp per cycle, then the cell row drops the victim and appends once the output is free.
// Reset empties the list and clears the access counter; entry storage is not cleared.
// A request is taken only while the result register is empty or being drained.
`include "tlb_fifo_lru_replacement_core_assert.svh"

module tlb_fifo_lru_replacement_core
	import tfl_pkg::*;
#(
	parameter int MAX_ENTRIES = TFL_MAX_ENTRIES,
	parameter int PID_BITS    = TFL_PID_BITS,
	parameter int PAGE_BITS   = TFL_PAGE_BITS,
	parameter int FRAME_BITS  = TFL_FRAME_BITS,
	localparam int IN_DW  = ((PID_BITS + PAGE_BITS + FRAME_BITS + 7) / 8) * 8,
	localparam int OUT_DW = ((FRAME_BITS + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_DW-1:0]  s_axis_tdata,   // process_id, page_number, frame_number
	input  logic [1:0]        s_axis_tuser,   // opcode
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_DW-1:0] m_axis_tdata,   // frame_out
	output logic [1:0]        m_axis_tuser,   // hit, replaced
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	tfl_state_t state_q, state_d;

	logic [TFL_EIU_BITS-1:0]   eiu_q;
	logic                      lru_q;
	logic [CW-1:0]             count_q;
	logic [TFL_STAMP_BITS-1:0] clock_q;
	logic [PID_BITS-1:0]       req_pid_q;
	logic [PAGE_BITS-1:0]      req_page_q;
	logic [FRAME_BITS-1:0]     req_frame_q;

	logic                      out_valid_q;
	logic                      hit_q;
	logic                      replaced_q;
	logic [FRAME_BITS-1:0]     frame_q;

	tfl_op_t                   cur_op;
	logic [PID_BITS-1:0]       cur_pid;
	logic [PAGE_BITS-1:0]      cur_page;
	logic [FRAME_BITS-1:0]     cur_frame;
	logic [CW-1:0]             limit;
	logic                      enabled;
	logic                      full;
	logic                      need_scan;
	logic                      out_free;
	logic                      in_fire;
	logic                      exec;
	logic                      scan_start;
	logic                      scan_run;
	logic                      scan_last;
	logic [IW-1:0]             scan_victim;
	logic [IW-1:0]             victim;
	logic                      do_ins;
	logic                      do_look;
	logic                      rep;
	logic [CW-1:0]             newcount;
	logic [FRAME_BITS-1:0]     hit_frame;

	logic [MAX_ENTRIES:0]                        found;
	logic [MAX_ENTRIES-1:0]                      first;
	logic [PID_BITS-1:0]                         cell_pid   [MAX_ENTRIES];
	logic [PAGE_BITS-1:0]                        cell_page  [MAX_ENTRIES];
	logic [FRAME_BITS-1:0]                       cell_frame [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0][TFL_STAMP_BITS-1:0] cell_stamp;
	logic [PID_BITS-1:0]                         nb_pid     [MAX_ENTRIES];
	logic [PAGE_BITS-1:0]                        nb_page    [MAX_ENTRIES];
	logic [FRAME_BITS-1:0]                       nb_frame   [MAX_ENTRIES];
	logic [TFL_STAMP_BITS-1:0]                   nb_stamp   [MAX_ENTRIES];
	tfl_cell_cmd_t                               cell_cmd   [MAX_ENTRIES];

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eiu_q <= '0;
			lru_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_ENTRIES: eiu_q <= pwdata[TFL_EIU_BITS-1:0];
				REG_POLICY:  lru_q <= pwdata[0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ENTRIES: prdata = 32'(eiu_q);
			REG_POLICY:  prdata = 32'(lru_q);
			default:     prdata = '0;
		endcase
	end

	always_comb begin
		if (32'(eiu_q) > 32'(MAX_ENTRIES)) begin
			limit = CW'(MAX_ENTRIES);
		end else begin
			limit = CW'(eiu_q);
		end
	end

	always_comb begin
		if (state_q == ST_FINISH) begin
			cur_op    = OP_INSERT;
			cur_pid   = req_pid_q;
			cur_page  = req_page_q;
			cur_frame = req_frame_q;
		end else begin
			cur_op    = tfl_op_t'(s_axis_tuser);
			cur_pid   = s_axis_tdata[PID_BITS-1:0];
			cur_page  = s_axis_tdata[PID_BITS+PAGE_BITS-1:PID_BITS];
			cur_frame = s_axis_tdata[PID_BITS+PAGE_BITS+FRAME_BITS-1:PID_BITS+PAGE_BITS];
		end
	end

	assign enabled   = limit != '0;
	assign full      = (count_q >= limit) && (count_q != '0);
	assign need_scan = (cur_op == OP_INSERT) && enabled && full && lru_q
		&& (count_q > CW'(1));
	assign out_free  = !out_valid_q || m_axis_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (scan_start) state_d = ST_SCAN;
			ST_SCAN:   if (scan_last) state_d = ST_FINISH;
			ST_FINISH: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE) && out_free;
		in_fire       = s_axis_tvalid && s_axis_tready;
		scan_start    = in_fire && need_scan;
		scan_run      = state_q == ST_SCAN;
		exec          = (in_fire && !need_scan) || ((state_q == ST_FINISH) && out_free);
		victim        = (state_q == ST_FINISH) ? scan_victim : '0;
		do_ins        = exec && (cur_op == OP_INSERT) && enabled;
		do_look       = exec && (cur_op == OP_LOOKUP) && enabled;
		rep           = do_ins && full;
		newcount      = count_q - CW'(rep);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_start) begin
			req_pid_q   <= cur_pid;
			req_page_q  <= cur_page;
			req_frame_q <= cur_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			clock_q <= '0;
		end else begin
			if (exec && (cur_op == OP_FLUSH)) begin
				count_q <= '0;
			end else if (do_ins) begin
				count_q <= newcount + CW'(newcount < CW'(MAX_ENTRIES));
			end
			if (do_ins || do_look) begin
				clock_q <= clock_q + TFL_STAMP_BITS'(1);
			end
		end
	end

	assign found[0] = 1'b0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		if (i < MAX_ENTRIES - 1) begin : g_nb
			assign nb_pid[i]   = cell_pid[i+1];
			assign nb_page[i]  = cell_page[i+1];
			assign nb_frame[i] = cell_frame[i+1];
			assign nb_stamp[i] = cell_stamp[i+1];
		end else begin : g_end
			assign nb_pid[i]   = cell_pid[i];
			assign nb_page[i]  = cell_page[i];
			assign nb_frame[i] = cell_frame[i];
			assign nb_stamp[i] = cell_stamp[i];
		end

		assign cell_cmd[i].load  = do_ins && (CW'(i) == newcount);
		assign cell_cmd[i].shift = rep && (IW'(i) >= victim) && (CW'(i + 1) < count_q);
		assign cell_cmd[i].touch = do_look && first[i];

		tfl_cell #(
			.PID_BITS  (PID_BITS),
			.PAGE_BITS (PAGE_BITS),
			.FRAME_BITS(FRAME_BITS)
		) u_cell (
			.clk       (clk),
			.cmd       (cell_cmd[i]),
			.valid     (CW'(i) < count_q),
			.key_pid   (cur_pid),
			.key_page  (cur_page),
			.new_frame (cur_frame),
			.stamp_now (clock_q),
			.nb_pid    (nb_pid[i]),
			.nb_page   (nb_page[i]),
			.nb_frame  (nb_frame[i]),
			.nb_stamp  (nb_stamp[i]),
			.found_in  (found[i]),
			.found_out (found[i+1]),
			.first     (first[i]),
			.pid       (cell_pid[i]),
			.page      (cell_page[i]),
			.frame     (cell_frame[i]),
			.stamp     (cell_stamp[i])
		);
	end

	always_comb begin
		hit_frame = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (first[i]) begin
				hit_frame = hit_frame | cell_frame[i];
			end
		end
	end

	tfl_victim_scan #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.run    (scan_run),
		.stamps (cell_stamp),
		.count  (count_q),
		.victim (scan_victim),
		.last   (scan_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			hit_q      <= do_look && found[MAX_ENTRIES];
			frame_q    <= (do_look && found[MAX_ENTRIES]) ? hit_frame : '0;
			replaced_q <= rep;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DW'(frame_q);
	assign m_axis_tuser  = {replaced_q, hit_q};

	`TFL_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(MAX_ENTRIES), "entry count above capacity")
	`TFL_ASSERT_NEXT(a_scan_holds_list, clk, arst_n, state_q == ST_SCAN, $stable(count_q), "list changed during victim search")
	`TFL_ASSERT_NOW(a_victim_in_list, clk, arst_n, state_q == ST_FINISH, CW'(scan_victim) < count_q, "victim outside the list")
	`TFL_ASSERT_NOW(a_hit_xor_replace, clk, arst_n, out_valid_q, !(hit_q && replaced_q), "result flags both hit and replaced")

endmodule
